@@ src/onbe_pkg.sv @@
// Shared constants, payload structs and helpers for the Oren-Nayar BRDF evaluator.
// No dependencies; imported by every module of the block.
package onbe_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int DIR_W      = 16;
    localparam int REG_W      = 17;
    localparam int VAL_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int SIN_W      = FRAC_BITS + 1;
    localparam int SQ_W       = 2 * FRAC_BITS + 1;
    localparam int ZSQ_W      = (2 * DIR_W > SQ_W) ? 2 * DIR_W : SQ_W;
    localparam int RQ_W       = 17;
    localparam int NUM_W      = DIR_W + 16;
    localparam int TB_W       = FRAC_BITS + 17;
    localparam int SIN_MIN    = (1 << FRAC_BITS) / 10000;
    localparam int INV_PI_Q16 = 20861;

    localparam logic [ZSQ_W-1:0] ONE_SQ      = ZSQ_W'(1) << (2 * FRAC_BITS);
    localparam logic [VAL_W-1:0] VAL_MAX     = {VAL_W{1'b1}};
    localparam logic [REG_W-1:0] COEFF_A_RST = REG_W'(65536);
    localparam logic [RQ_W-1:0]  RATIO_ONE   = RQ_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEFF_A = 3'd0,
        REG_COEFF_B = 3'd1,
        REG_REFL_R  = 3'd2,
        REG_REFL_G  = 3'd3,
        REG_REFL_B  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [DIR_W-1:0] xo;
        logic [DIR_W-1:0] yo;
        logic [DIR_W-1:0] zo;
        logic [DIR_W-1:0] xi;
        logic [DIR_W-1:0] yi;
        logic [DIR_W-1:0] zi;
    } onbe_dir_t;

    typedef struct packed {
        logic [DIR_W-1:0] xo;
        logic [DIR_W-1:0] yo;
        logic [DIR_W-1:0] xi;
        logic [DIR_W-1:0] yi;
        logic [DIR_W-1:0] azo;
        logic [DIR_W-1:0] azi;
        logic [SIN_W-1:0] so;
        logic [SIN_W-1:0] si;
    } onbe_geo_t;

    // ratio index: 3 = x out, 2 = y out, 1 = x in, 0 = y in
    typedef struct packed {
        logic [3:0][RQ_W-1:0] q;
        logic [3:0]           big;
        logic [3:0]           neg;
        logic [SIN_W-1:0]     sa;
        logic [TB_W-1:0]      tb;
        logic                 cos_ok;
        logic                 den_zero;
    } onbe_quot_t;

    typedef struct packed {
        logic [REG_W-1:0] coeff_a;
        logic [REG_W-1:0] coeff_b;
        logic [REG_W-1:0] refl_r;
        logic [REG_W-1:0] refl_g;
        logic [REG_W-1:0] refl_b;
    } onbe_cfg_t;

    function automatic logic [DIR_W-1:0] mag(input logic [DIR_W-1:0] v);
        return v[DIR_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

@@ src/onbe_sqrt.sv @@
// Front pipeline: squares |z| and extracts sin theta = isqrt(1 - z^2) one bit per stage.
// Depends on onbe_pkg.
module onbe_sqrt
    import onbe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  onbe_dir_t dir,
    output logic      out_valid,
    output onbe_geo_t geo
);

    localparam int TW = SQ_W + 2;

    typedef struct packed {
        logic [DIR_W-1:0] xo;
        logic [DIR_W-1:0] yo;
        logic [DIR_W-1:0] xi;
        logic [DIR_W-1:0] yi;
        logic [DIR_W-1:0] azo;
        logic [DIR_W-1:0] azi;
        logic [ZSQ_W-1:0] zso;
        logic [ZSQ_W-1:0] zsi;
    } sq_t;

    typedef struct packed {
        logic [DIR_W-1:0] xo;
        logic [DIR_W-1:0] yo;
        logic [DIR_W-1:0] xi;
        logic [DIR_W-1:0] yi;
        logic [DIR_W-1:0] azo;
        logic [DIR_W-1:0] azi;
        logic [SQ_W-1:0]  remo;
        logic [SQ_W-1:0]  remi;
        logic [SIN_W-1:0] ro;
        logic [SIN_W-1:0] ri;
    } rt_t;

    sq_t              sq_reg;
    sq_t              sq_next;
    rt_t              rt_reg  [SIN_W+1];
    rt_t              rt_next [SIN_W+1];
    logic [SIN_W+1:0] v_reg;

    function automatic logic [SQ_W-1:0] sin_sq(input logic [ZSQ_W-1:0] zs);
        return (zs >= ONE_SQ) ? '0 : SQ_W'(ONE_SQ - zs);
    endfunction

    always_comb
    begin
        sq_next.xo  = dir.xo;
        sq_next.yo  = dir.yo;
        sq_next.xi  = dir.xi;
        sq_next.yi  = dir.yi;
        sq_next.azo = mag(dir.zo);
        sq_next.azi = mag(dir.zi);
        sq_next.zso = ZSQ_W'(sq_next.azo) * ZSQ_W'(sq_next.azo);
        sq_next.zsi = ZSQ_W'(sq_next.azi) * ZSQ_W'(sq_next.azi);
    end

    // remainder form: rem = v - r^2, one result bit per stage from the top
    always_comb
    begin
        logic [TW-1:0] test_o;
        logic [TW-1:0] test_i;
        rt_next[0].xo   = sq_reg.xo;
        rt_next[0].yo   = sq_reg.yo;
        rt_next[0].xi   = sq_reg.xi;
        rt_next[0].yi   = sq_reg.yi;
        rt_next[0].azo  = sq_reg.azo;
        rt_next[0].azi  = sq_reg.azi;
        rt_next[0].remo = sin_sq(sq_reg.zso);
        rt_next[0].remi = sin_sq(sq_reg.zsi);
        rt_next[0].ro   = '0;
        rt_next[0].ri   = '0;
        for (int k = 0; k < SIN_W; k++)
        begin
            rt_next[k+1] = rt_reg[k];
            test_o = (TW'(rt_reg[k].ro) << (SIN_W - k)) + (TW'(1) << (2 * (SIN_W - 1 - k)));
            test_i = (TW'(rt_reg[k].ri) << (SIN_W - k)) + (TW'(1) << (2 * (SIN_W - 1 - k)));
            if (TW'(rt_reg[k].remo) >= test_o)
            begin
                rt_next[k+1].remo            = SQ_W'(TW'(rt_reg[k].remo) - test_o);
                rt_next[k+1].ro[SIN_W-1-k]   = 1'b1;
            end
            if (TW'(rt_reg[k].remi) >= test_i)
            begin
                rt_next[k+1].remi            = SQ_W'(TW'(rt_reg[k].remi) - test_i);
                rt_next[k+1].ri[SIN_W-1-k]   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[SIN_W:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= sq_next;
            for (int k = 0; k <= SIN_W; k++)
            begin
                rt_reg[k] <= rt_next[k];
            end
        end
    end

    assign out_valid = v_reg[SIN_W+1];
    assign geo.xo    = rt_reg[SIN_W].xo;
    assign geo.yo    = rt_reg[SIN_W].yo;
    assign geo.xi    = rt_reg[SIN_W].xi;
    assign geo.yi    = rt_reg[SIN_W].yi;
    assign geo.azo   = rt_reg[SIN_W].azo;
    assign geo.azi   = rt_reg[SIN_W].azi;
    assign geo.so    = rt_reg[SIN_W].ro;
    assign geo.si    = rt_reg[SIN_W].ri;

endmodule

@@ src/onbe_div.sv @@
// Division pipeline: four azimuth ratios (Q.16) and tan beta, one quotient bit per stage.
// Depends on onbe_pkg.
module onbe_div
    import onbe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  onbe_geo_t  geo,
    output logic       out_valid,
    output onbe_quot_t quot
);

    localparam int CW  = ((NUM_W > SIN_W + RQ_W) ? NUM_W : SIN_W + RQ_W) + 1;
    localparam int TCW = DIR_W + TB_W;

    typedef struct packed {
        logic [3:0][NUM_W-1:0] n;
        logic [3:0][RQ_W-1:0]  q;
        logic [3:0]            big;
        logic [3:0]            neg;
        logic [SIN_W-1:0]      so;
        logic [SIN_W-1:0]      si;
        logic [TB_W-1:0]       tn;
        logic [TB_W-1:0]       tq;
        logic [DIR_W-1:0]      den;
        logic [SIN_W-1:0]      sa;
        logic                  cos_ok;
        logic                  den_zero;
    } dv_t;

    dv_t           dv_reg  [TB_W+1];
    dv_t           dv_next [TB_W+1];
    logic [TB_W:0] v_reg;

    always_comb
    begin
        logic [3:0][DIR_W-1:0] c;
        logic [CW-1:0]         dsh;
        logic [TCW-1:0]        tsh;
        int                    br;
        c = {geo.xo, geo.yo, geo.xi, geo.yi};
        dv_next[0].so = geo.so;
        dv_next[0].si = geo.si;
        for (int j = 0; j < 4; j++)
        begin
            dv_next[0].n[j]   = NUM_W'(mag(c[j])) << 16;
            dv_next[0].q[j]   = '0;
            dv_next[0].neg[j] = c[j][DIR_W-1];
            dsh = CW'(j >= 2 ? geo.so : geo.si) << RQ_W;
            dv_next[0].big[j] = CW'(dv_next[0].n[j]) >= dsh;
        end
        dv_next[0].cos_ok = (geo.si > SIN_W'(SIN_MIN)) && (geo.so > SIN_W'(SIN_MIN));
        if (geo.azi > geo.azo)
        begin
            dv_next[0].sa  = geo.so;
            dv_next[0].tn  = TB_W'(geo.si) << 16;
            dv_next[0].den = geo.azi;
        end
        else
        begin
            dv_next[0].sa  = geo.si;
            dv_next[0].tn  = TB_W'(geo.so) << 16;
            dv_next[0].den = geo.azo;
        end
        dv_next[0].den_zero = (dv_next[0].den == '0);
        dv_next[0].tq       = '0;

        for (int k = 0; k < TB_W; k++)
        begin
            dv_next[k+1] = dv_reg[k];
            tsh = TCW'(dv_reg[k].den) << (TB_W - 1 - k);
            if (tsh <= TCW'(dv_reg[k].tn))
            begin
                dv_next[k+1].tn           = TB_W'(TCW'(dv_reg[k].tn) - tsh);
                dv_next[k+1].tq[TB_W-1-k] = 1'b1;
            end
            if (k < RQ_W)
            begin
                br = RQ_W - 1 - k;
                for (int j = 0; j < 4; j++)
                begin
                    dsh = CW'(j >= 2 ? dv_reg[k].so : dv_reg[k].si) << br;
                    if (dsh <= CW'(dv_reg[k].n[j]))
                    begin
                        dv_next[k+1].n[j]     = NUM_W'(CW'(dv_reg[k].n[j]) - dsh);
                        dv_next[k+1].q[j][br] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[TB_W-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= TB_W; k++)
            begin
                dv_reg[k] <= dv_next[k];
            end
        end
    end

    assign out_valid     = v_reg[TB_W];
    assign quot.q        = dv_reg[TB_W].q;
    assign quot.big      = dv_reg[TB_W].big;
    assign quot.neg      = dv_reg[TB_W].neg;
    assign quot.sa       = dv_reg[TB_W].sa;
    assign quot.tb       = dv_reg[TB_W].tq;
    assign quot.cos_ok   = dv_reg[TB_W].cos_ok;
    assign quot.den_zero = dv_reg[TB_W].den_zero;

endmodule

@@ src/onbe_mul.sv @@
// Back-end multiply pipeline: max cosine, A + B term, per-channel scaling and saturation.
// Depends on onbe_pkg; its last stage is the output register.
module onbe_mul
    import onbe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  onbe_quot_t       quot,
    input  onbe_cfg_t        cfg,
    output logic             out_valid,
    output logic [VAL_W-1:0] value_red,
    output logic [VAL_W-1:0] value_green,
    output logic [VAL_W-1:0] value_blue,
    output logic             saturated
);

    localparam int RS_W  = RQ_W + 1;
    localparam int PR_W  = 2 * RS_W;
    localparam int D_W   = PR_W + 1;
    localparam int MC_W  = D_W - 17;
    localparam int STF_W = SIN_W + TB_W;
    localparam int ST_W  = STF_W - FRAC_BITS;
    localparam int TP_W  = MC_W + ST_W;
    localparam int T_W   = TP_W - 16;
    localparam int BP_W  = REG_W + T_W;
    localparam int B_W   = BP_W - 16;
    localparam int SUM_W = B_W + 1;
    localparam int SL    = SUM_W / 2;
    localparam int SH    = SUM_W - SL;
    localparam int PL_W  = REG_W + SL;
    localparam int PH_W  = REG_W + SH;
    localparam int P2_W  = REG_W + SUM_W;
    localparam int PC_W  = VAL_W + 2;   // anything at or above 2^PC_W clips anyway
    localparam int IP_W  = 15;
    localparam int VP_W  = PC_W + IP_W;
    localparam int V_W   = VP_W - 16;
    localparam logic [IP_W-1:0] INV_PI = IP_W'(INV_PI_Q16);

    logic [8:0] v_reg;
    logic [7:0] dz_reg;
    logic [1:0] cok_reg;

    logic signed [3:0][RS_W-1:0] rs_reg;
    logic signed [3:0][RS_W-1:0] rs_next;
    logic [SIN_W-1:0]            sa_reg;
    logic [TB_W-1:0]             tb_reg;
    logic signed [PR_W-1:0]      px_reg;
    logic signed [PR_W-1:0]      py_reg;
    logic [STF_W-1:0]            stf_reg;
    logic signed [D_W-1:0]       d_sum;
    logic [MC_W-1:0]             mc_reg;
    logic [MC_W-1:0]             mc_next;
    logic [ST_W-1:0]             st_reg;
    logic [TP_W-1:0]             tp;
    logic [T_W-1:0]              t_reg;
    logic [BP_W-1:0]             bp;
    logic [B_W-1:0]              b_reg;
    logic [SUM_W-1:0]            sum_reg;
    logic [2:0][REG_W-1:0]       refl;
    logic [2:0][PL_W-1:0]        pl_reg;
    logic [2:0][PH_W-1:0]        ph_reg;
    logic [2:0][PC_W-1:0]        pc_reg;
    logic [2:0][PC_W-1:0]        pc_next;
    logic [2:0][VAL_W-1:0]       val_reg;
    logic [2:0][VAL_W-1:0]       val_next;
    logic                        sat_reg;
    logic                        sat_next;

    assign refl = {cfg.refl_r, cfg.refl_g, cfg.refl_b};

    always_comb
    begin
        logic [RQ_W-1:0] r;
        logic [RS_W-1:0] m;
        for (int j = 0; j < 4; j++)
        begin
            r = (quot.big[j] || quot.q[j] > RATIO_ONE) ? RATIO_ONE : quot.q[j];
            m = RS_W'(r);
            rs_next[j] = quot.neg[j] ? RS_W'(~m + 1'b1) : m;
        end
    end

    assign d_sum   = D_W'(px_reg) + D_W'(py_reg);
    assign mc_next = (cok_reg[1] && d_sum > 0) ? d_sum[D_W-2:16] : '0;
    assign tp      = TP_W'(mc_reg) * TP_W'(st_reg);
    assign bp      = BP_W'(cfg.coeff_b) * BP_W'(t_reg);

    always_comb
    begin
        logic [P2_W-1:0] p;
        logic [VP_W-1:0] vp;
        logic [V_W-1:0]  v;
        sat_next = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            p = (P2_W'(pl_reg[c]) + (P2_W'(ph_reg[c]) << SL)) >> 16;
            pc_next[c] = (|p[P2_W-1:PC_W]) ? {PC_W{1'b1}} : p[PC_W-1:0];
            vp = VP_W'(pc_reg[c]) * VP_W'(INV_PI);
            v  = vp[VP_W-1:16];
            if (dz_reg[7] || v > V_W'(VAL_MAX))
            begin
                val_next[c] = VAL_MAX;
                sat_next    = 1'b1;
            end
            else
            begin
                val_next[c] = v[VAL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[7:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dz_reg  <= {dz_reg[6:0], quot.den_zero};
            cok_reg <= {cok_reg[0], quot.cos_ok};
            rs_reg  <= rs_next;
            sa_reg  <= quot.sa;
            tb_reg  <= quot.tb;
            px_reg  <= $signed(rs_reg[3]) * $signed(rs_reg[1]);
            py_reg  <= $signed(rs_reg[2]) * $signed(rs_reg[0]);
            stf_reg <= STF_W'(sa_reg) * STF_W'(tb_reg);
            mc_reg  <= mc_next;
            st_reg  <= stf_reg[STF_W-1:FRAC_BITS];
            t_reg   <= tp[TP_W-1:16];
            b_reg   <= bp[BP_W-1:16];
            sum_reg <= SUM_W'(cfg.coeff_a) + SUM_W'(b_reg);
            for (int c = 0; c < 3; c++)
            begin
                pl_reg[c] <= PL_W'(refl[c]) * PL_W'(sum_reg[SL-1:0]);
                ph_reg[c] <= PH_W'(refl[c]) * PH_W'(sum_reg[SUM_W-1:SL]);
            end
            pc_reg  <= pc_next;
            val_reg <= val_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid   = v_reg[8];
    assign value_red   = val_reg[2];
    assign value_green = val_reg[1];
    assign value_blue  = val_reg[0];
    assign saturated   = sat_reg;

endmodule

@@ src/oren_nayar_brdf_eval_core.sv @@
// Oren-Nayar diffuse BRDF evaluator top level: configuration registers, input skid, pipeline.
// Depends on onbe_pkg, onbe_sqrt, onbe_div and onbe_mul.
//
// Takes one pair of unit directions (Q1.14, z is the normal) per beat and returns
// reflectance/pi * (A + B * max(0, cos dphi) * sin(alpha) * tan(beta)) for three channels
// in Q4.16, saturating, with a flag for clipping or both |z| zero. One pair is accepted
// every cycle while the skid register is empty. A beat passes through the bit-per-stage
// square root (17 stages including the square), the bit-per-stage tan beta divider
// (32 stages) and the 9-stage multiply chain, all of which halt while the output is held.
// A one-entry skid register lets one more beat in while the output is held. A, B and the
// three reflectances are to be written by software only while the block is idle, which the
// block does not enforce; writes to unused indexes are ignored.
module oren_nayar_brdf_eval_core
    import onbe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [REG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [DIR_W-1:0]     out_dir_x,
    input  logic [DIR_W-1:0]     out_dir_y,
    input  logic [DIR_W-1:0]     out_dir_z,
    input  logic [DIR_W-1:0]     in_dir_x,
    input  logic [DIR_W-1:0]     in_dir_y,
    input  logic [DIR_W-1:0]     in_dir_z,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [VAL_W-1:0]     value_red,
    output logic [VAL_W-1:0]     value_green,
    output logic [VAL_W-1:0]     value_blue,
    output logic                 saturated
);

    onbe_cfg_t  cfg_reg;
    onbe_cfg_t  cfg_next;
    logic       skid_valid_reg;
    logic       skid_valid_next;
    onbe_dir_t  skid_reg;
    onbe_dir_t  in_dir;
    onbe_dir_t  pipe_dir;
    logic       pipe_valid;
    logic       en;
    logic       geo_valid;
    onbe_geo_t  geo;
    logic       quot_valid;
    onbe_quot_t quot;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                REG_COEFF_A: cfg_next.coeff_a = cfg_data;
                REG_COEFF_B: cfg_next.coeff_b = cfg_data;
                REG_REFL_R:  cfg_next.refl_r  = cfg_data;
                REG_REFL_G:  cfg_next.refl_g  = cfg_data;
                REG_REFL_B:  cfg_next.refl_b  = cfg_data;
                default:     cfg_next         = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coeff_a <= COEFF_A_RST;
            cfg_reg.coeff_b <= '0;
            cfg_reg.refl_r  <= '0;
            cfg_reg.refl_g  <= '0;
            cfg_reg.refl_b  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // whole pipeline moves when the output register is free or being taken
    assign en       = !out_valid || out_ready;
    assign in_ready = !skid_valid_reg;
    assign in_dir   = {out_dir_x, out_dir_y, out_dir_z, in_dir_x, in_dir_y, in_dir_z};

    assign pipe_valid = skid_valid_reg || in_valid;
    assign pipe_dir   = skid_valid_reg ? skid_reg : in_dir;

    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        if (en)
        begin
            skid_valid_next = 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en && in_valid && in_ready)
        begin
            skid_reg <= in_dir;
        end
    end

    onbe_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pipe_valid),
        .dir       (pipe_dir),
        .out_valid (geo_valid),
        .geo       (geo)
    );

    onbe_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (geo_valid),
        .geo       (geo),
        .out_valid (quot_valid),
        .quot      (quot)
    );

    onbe_mul u_mul (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (quot_valid),
        .quot        (quot),
        .cfg         (cfg_reg),
        .out_valid   (out_valid),
        .value_red   (value_red),
        .value_green (value_green),
        .value_blue  (value_blue),
        .saturated   (saturated)
    );

endmodule
